[rtl/ppie_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and dictionary ROM of the pinyin prefix input engine.
package ppie_pkg;

  localparam int unsigned RomLetters = 10;
  localparam int unsigned OutCands   = 5;
  localparam int unsigned RomRows    = 10;

  localparam logic [7:0] KeyLowA      = 8'h61;
  localparam logic [7:0] KeyLowZ      = 8'h7a;
  localparam logic [7:0] KeyDigitZero = 8'h30;
  localparam logic [7:0] KeyDigitOne  = 8'h31;
  localparam logic [7:0] KeyBackspace = 8'd8;
  localparam logic [7:0] KeyEnter     = 8'd10;

  typedef enum logic [2:0] {
    ActIgnore   = 3'd0,
    ActLetter   = 3'd1,
    ActCommit   = 3'd2,
    ActSpellBs  = 3'd3,
    ActCommitBs = 3'd4,
    ActClear    = 3'd5,
    ActExit     = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StScan,
    StCommitRd,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load_key;
    logic    append_letter;
    logic    drop_letter;
    logic    clear_spell;
    logic    scan_start;
    logic    scan_step;
    logic    commit_read;
    logic    commit_write;
    logic    drop_commit;
    logic    set_action;
    action_e action;
    logic    load_out;
  } ppie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_letter;
    logic is_digit;
    logic is_bs;
    logic is_enter;
    logic spell_full;
    logic spell_empty;
    logic pick_ok;
    logic store_full;
    logic store_empty;
    logic cand_empty;
    logic scan_done;
  } ppie_sts_t;

  typedef logic [5*RomLetters-1:0] rom_spell_t;

  // letter codes 1..26, 0 ends the spelling; five bits per letter, first at LSB
  function automatic logic [4:0] rom_letter(input int unsigned row, input int unsigned pos);
    logic [7:0] s [RomLetters];
    logic [4:0] r;
    for (int unsigned k = 0; k < RomLetters; k++) s[k] = 8'h0;
    case (row)
      0: begin s[0]="n"; s[1]="i"; end
      1: begin s[0]="h"; s[1]="a"; s[2]="o"; end
      2: begin s[0]="m"; s[1]="a"; end
      3: begin s[0]="w"; s[1]="o"; end
      4: begin s[0]="t"; s[1]="a"; end
      5: begin s[0]="m"; s[1]="e"; s[2]="n"; end
      6: begin s[0]="r"; s[1]="e"; s[2]="n"; end
      7: begin s[0]="d"; s[1]="a"; end
      8: begin s[0]="z"; s[1]="h"; s[2]="o"; s[3]="n"; s[4]="g"; end
      9: begin s[0]="g"; s[1]="u"; s[2]="o"; end
      default: ;
    endcase
    r = 5'd0;
    if (pos < RomLetters && s[pos] != 8'h0) r = 5'(s[pos] - 8'h60);
    return r;
  endfunction

  function automatic rom_spell_t rom_spell(input int unsigned row);
    rom_spell_t v;
    for (int unsigned p = 0; p < RomLetters; p++) v[5*p +: 5] = rom_letter(row, p);
    return v;
  endfunction

  function automatic logic [15:0] rom_code(input int unsigned row);
    logic [15:0] c;
    case (row)
      0: c = 16'hC4E3;
      1: c = 16'hBAC3;
      2: c = 16'hC2F0;
      3: c = 16'hCED2;
      4: c = 16'hCBFB;
      5: c = 16'hC3C7;
      6: c = 16'hC8CB;
      7: c = 16'hB4F3;
      8: c = 16'hD6D0;
      9: c = 16'hB9FA;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

[rtl/ppie_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences decode, dictionary scan, commit and result.
module ppie_ctrl import ppie_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ppie_sts_t sts_i,
  output ppie_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    cmd_o.action = ActIgnore;
    in_ready = 1'b0;
    if (ovalid_q && out_ready) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_key = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        cmd_o.set_action = 1'b1;
        state_d = StOut;
        if (sts_i.is_letter) begin
          if (!sts_i.spell_full) begin
            cmd_o.action = ActLetter;
            cmd_o.append_letter = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d = StScan;
          end
        end else if (sts_i.is_digit) begin
          if (sts_i.pick_ok && !sts_i.store_full) begin
            cmd_o.action = ActCommit;
            cmd_o.commit_read = 1'b1;
            state_d = StCommitRd;
          end
        end else if (sts_i.is_bs) begin
          if (!sts_i.spell_empty) begin
            cmd_o.action = ActSpellBs;
            cmd_o.drop_letter = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d = StScan;
          end else if (!sts_i.store_empty) begin
            cmd_o.action = ActCommitBs;
            cmd_o.drop_commit = 1'b1;
          end
        end else if (sts_i.is_enter) begin
          if (sts_i.spell_empty && sts_i.cand_empty) begin
            cmd_o.action = ActExit;
          end else begin
            cmd_o.action = ActClear;
            cmd_o.clear_spell = 1'b1;
          end
        end
      end
      StScan: begin
        if (sts_i.scan_done) state_d = StOut;
        else cmd_o.scan_step = 1'b1;
      end
      StCommitRd: begin
        cmd_o.commit_write = 1'b1;
        cmd_o.clear_spell = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        // wait for the output register to free up
        if (!ovalid_q || out_ready) begin
          cmd_o.load_out = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

[rtl/ppie_dp.sv]
`timescale 1ns / 1ps
// Datapath: spelling buffer, candidate list, committed store and output register.
module ppie_dp import ppie_pkg::*; #(
  parameter int unsigned SpellingMax  = 10,
  parameter int unsigned CandidateMax = 5,
  parameter int unsigned CommittedMax = 32,
  parameter int unsigned DictEntries  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  key_code_i,
  input  ppie_cmd_t   cmd_i,
  output ppie_sts_t   sts_o,
  output logic [2:0]  action_taken_o,
  output logic [3:0]  spelling_length_o,
  output logic [2:0]  candidate_count_o,
  output logic [15:0] candidate_code_0_o,
  output logic [15:0] candidate_code_1_o,
  output logic [15:0] candidate_code_2_o,
  output logic [15:0] candidate_code_3_o,
  output logic [15:0] candidate_code_4_o,
  output logic [5:0]  committed_length_o,
  output logic [15:0] committed_code_o
);

  localparam int unsigned SW  = $clog2(SpellingMax + 1);
  localparam int unsigned SI  = (SpellingMax > 1) ? $clog2(SpellingMax) : 1;
  localparam int unsigned CW  = $clog2(CandidateMax + 1);
  localparam int unsigned CI  = (CandidateMax > 1) ? $clog2(CandidateMax) : 1;
  localparam int unsigned MW  = $clog2(CommittedMax + 1);
  localparam int unsigned MI  = (CommittedMax > 1) ? $clog2(CommittedMax) : 1;
  localparam int unsigned RW  = $clog2(DictEntries + 1);
  localparam int unsigned RI  = (DictEntries > 1) ? $clog2(DictEntries) : 1;

  logic [7:0]    key_q;
  logic [4:0]    spell_q [SpellingMax];
  logic [SW-1:0] scount_q;
  logic [15:0]   cand_q [CandidateMax];
  logic [CW-1:0] ctotal_q;
  logic [15:0]   store_q [CommittedMax];
  logic [MW-1:0] mtotal_q;
  logic [RW-1:0] row_q;
  logic [15:0]   pick_q;
  action_e       act_q;

  // dictionary ROM as constant arrays
  rom_spell_t  rom_sp [DictEntries];
  logic [15:0] rom_cd [DictEntries];
  always_comb begin
    for (int unsigned r = 0; r < DictEntries; r++) begin
      rom_sp[r] = rom_spell(r);
      rom_cd[r] = rom_code(r);
    end
  end

  // key decode
  logic [7:0] dig_lim;
  logic       is_letter, is_digit;
  logic [CI-1:0] pick_idx;
  assign is_letter = (key_q >= KeyLowA) && (key_q <= KeyLowZ);
  assign dig_lim   = KeyDigitZero + 8'(ctotal_q);
  assign is_digit  = (key_q >= KeyDigitOne) && (key_q <= dig_lim);
  assign pick_idx  = CI'(key_q - KeyDigitOne);

  // prefix compare of the current row
  rom_spell_t  cur_sp;
  logic [15:0] cur_cd;
  logic        hit;
  assign cur_sp = rom_sp[row_q[RI-1:0]];
  assign cur_cd = rom_cd[row_q[RI-1:0]];
  always_comb begin
    hit = (scount_q != '0);
    for (int unsigned p = 0; p < SpellingMax; p++) begin
      if (SW'(p) < scount_q) begin
        if (p >= RomLetters) hit = 1'b0;
        else if (cur_sp[5*p +: 5] != spell_q[p]) hit = 1'b0;
      end
    end
  end

  logic scan_done;
  assign scan_done = (row_q >= RW'(DictEntries)) || (ctotal_q >= CW'(CandidateMax))
                     || (scount_q == '0);

  assign sts_o.is_letter   = is_letter;
  assign sts_o.is_digit    = is_digit;
  assign sts_o.is_bs       = (key_q == KeyBackspace);
  assign sts_o.is_enter    = (key_q == KeyEnter);
  assign sts_o.spell_full  = (scount_q >= SW'(SpellingMax));
  assign sts_o.spell_empty = (scount_q == '0);
  assign sts_o.pick_ok     = ({1'b0, pick_idx} < (CI+1)'(ctotal_q));
  assign sts_o.store_full  = (mtotal_q >= MW'(CommittedMax));
  assign sts_o.store_empty = (mtotal_q == '0);
  assign sts_o.cand_empty  = (ctotal_q == '0);
  assign sts_o.scan_done   = scan_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) key_q <= key_code_i;
    if (cmd_i.append_letter) spell_q[scount_q[SI-1:0]] <= 5'(key_q - KeyLowA + 8'd1);
    if (cmd_i.scan_step && hit) cand_q[ctotal_q[CI-1:0]] <= cur_cd;
    if (cmd_i.commit_read) pick_q <= cand_q[pick_idx];
    if (cmd_i.commit_write) store_q[mtotal_q[MI-1:0]] <= pick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scount_q <= '0;
      ctotal_q <= '0;
      mtotal_q <= '0;
      row_q    <= '0;
      act_q    <= ActIgnore;
    end else begin
      if (cmd_i.set_action) act_q <= cmd_i.action;
      if (cmd_i.append_letter) scount_q <= scount_q + SW'(1);
      if (cmd_i.drop_letter) scount_q <= scount_q - SW'(1);
      if (cmd_i.scan_start) begin
        row_q    <= '0;
        ctotal_q <= '0;
      end
      if (cmd_i.scan_step) begin
        row_q <= row_q + RW'(1);
        if (hit) ctotal_q <= ctotal_q + CW'(1);
      end
      if (cmd_i.clear_spell) begin
        scount_q <= '0;
        ctotal_q <= '0;
      end
      if (cmd_i.commit_write) mtotal_q <= mtotal_q + MW'(1);
      if (cmd_i.drop_commit) mtotal_q <= mtotal_q - MW'(1);
    end
  end

  // output register
  logic [15:0] cand_out [OutCands];
  always_comb begin
    for (int unsigned i = 0; i < OutCands; i++) begin
      cand_out[i] = 16'h0;
      if (i < CandidateMax && CW'(i) < ctotal_q) cand_out[i] = cand_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_taken_o     <= act_q;
      spelling_length_o  <= 4'(scount_q);
      candidate_count_o  <= 3'(ctotal_q);
      candidate_code_0_o <= cand_out[0];
      candidate_code_1_o <= cand_out[1];
      candidate_code_2_o <= cand_out[2];
      candidate_code_3_o <= cand_out[3];
      candidate_code_4_o <= cand_out[4];
      committed_length_o <= 6'(mtotal_q);
      committed_code_o   <= (act_q == ActCommit) ? pick_q : 16'h0;
    end
  end

endmodule

[rtl/pinyin_prefix_input_engine.sv]
`timescale 1ns / 1ps
// Top level of the pinyin prefix input engine.
//
// One key code enters on the input channel (in_valid/in_ready); one result
// leaves on the output channel (out_valid/out_ready) for every key.
// The block works on one key at a time. A key is decoded in StDecode;
// a letter or a spelling backspace then rescans the dictionary ROM one
// entry per cycle, stopping after the last entry, when the candidate
// list is full, or at once when the spelling is empty. A commit reads
// the candidate in StDecode and writes the store in StCommitRd; then,
// like every other key, it waits in StOut for the output register. The
// next key can be taken in the cycle after the result is loaded.
// The result sits in an output register; the next key is taken while it
// waits. If the receiver stalls, the following result holds in the datapath
// until the register is free, and no further key is taken.
// Reset clears the spelling, candidate and committed counts and the
// output valid flag; store contents are unused until written.
module pinyin_prefix_input_engine import ppie_pkg::*; #(
  parameter int unsigned SpellingMax  = 10,
  parameter int unsigned CandidateMax = 5,
  parameter int unsigned CommittedMax = 32,
  parameter int unsigned DictEntries  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  key_code_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action_taken_o,
  output logic [3:0]  spelling_length_o,
  output logic [2:0]  candidate_count_o,
  output logic [15:0] candidate_code_0_o,
  output logic [15:0] candidate_code_1_o,
  output logic [15:0] candidate_code_2_o,
  output logic [15:0] candidate_code_3_o,
  output logic [15:0] candidate_code_4_o,
  output logic [5:0]  committed_length_o,
  output logic [15:0] committed_code_o
);

  ppie_cmd_t cmd;
  ppie_sts_t sts;

  ppie_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ppie_dp #(
    .SpellingMax  (SpellingMax),
    .CandidateMax (CandidateMax),
    .CommittedMax (CommittedMax),
    .DictEntries  (DictEntries)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .key_code_i         (key_code_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_taken_o     (action_taken_o),
    .spelling_length_o  (spelling_length_o),
    .candidate_count_o  (candidate_count_o),
    .candidate_code_0_o (candidate_code_0_o),
    .candidate_code_1_o (candidate_code_1_o),
    .candidate_code_2_o (candidate_code_2_o),
    .candidate_code_3_o (candidate_code_3_o),
    .candidate_code_4_o (candidate_code_4_o),
    .committed_length_o (committed_length_o),
    .committed_code_o   (committed_code_o)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the pinyin prefix input engine.
module tb;
  import ppie_pkg::*;

  typedef struct packed {
    action_e     action;
    logic [3:0]  spell_len;
    logic [2:0]  cand_cnt;
    logic [15:0] cand0;
    logic [15:0] cand1;
    logic [15:0] cand2;
    logic [15:0] cand3;
    logic [15:0] cand4;
    logic [5:0]  commit_len;
    logic [15:0] commit_code;
  } key_result_t;

  localparam int unsigned SpellCap  = 10;
  localparam int unsigned CandCap   = 5;
  localparam int unsigned StoreCap  = 32;
  localparam int unsigned WordCount = 10;
  localparam int unsigned StallLimit = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  key_code_i;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  action_taken_o;
  logic [3:0]  spelling_length_o;
  logic [2:0]  candidate_count_o;
  logic [15:0] candidate_code_0_o;
  logic [15:0] candidate_code_1_o;
  logic [15:0] candidate_code_2_o;
  logic [15:0] candidate_code_3_o;
  logic [15:0] candidate_code_4_o;
  logic [5:0]  committed_length_o;
  logic [15:0] committed_code_o;

  pinyin_prefix_input_engine u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .key_code_i         (key_code_i),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action_taken_o     (action_taken_o),
    .spelling_length_o  (spelling_length_o),
    .candidate_count_o  (candidate_count_o),
    .candidate_code_0_o (candidate_code_0_o),
    .candidate_code_1_o (candidate_code_1_o),
    .candidate_code_2_o (candidate_code_2_o),
    .candidate_code_3_o (candidate_code_3_o),
    .candidate_code_4_o (candidate_code_4_o),
    .committed_length_o (committed_length_o),
    .committed_code_o   (committed_code_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // dictionary copy for prediction
  string       word_spell [WordCount];
  logic [15:0] word_code  [WordCount];

  // predicted engine state
  logic [4:0]  spell_buf [SpellCap];
  int unsigned spell_cnt;
  logic [15:0] cand_buf [CandCap];
  int unsigned cand_cnt;
  int unsigned store_cnt;

  key_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned sent_keys;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off;
  int unsigned quiet_cycles;

  function automatic logic [4:0] word_letter(int unsigned row, int unsigned pos);
    if (pos >= word_spell[row].len()) return 5'd0;
    return 5'(word_spell[row][pos] - 8'h60);
  endfunction

  function automatic void lookup_prefix();
    logic hit;
    cand_cnt = 0;
    if (spell_cnt == 0) return;
    for (int unsigned r = 0; r < WordCount && cand_cnt < CandCap; r++) begin
      hit = 1'b1;
      for (int unsigned p = 0; p < spell_cnt; p++)
        if (word_letter(r, p) != spell_buf[p]) hit = 1'b0;
      if (hit) begin
        cand_buf[cand_cnt] = word_code[r];
        cand_cnt++;
      end
    end
  endfunction

  function automatic key_result_t apply_key(logic [7:0] k);
    key_result_t res;
    logic [15:0] cands [CandCap];
    res = '0;
    res.action = ActIgnore;
    if (k >= KeyLowA && k <= KeyLowZ) begin
      if (spell_cnt < SpellCap) begin
        spell_buf[spell_cnt] = 5'(k - 8'h60);
        spell_cnt++;
        lookup_prefix();
        res.action = ActLetter;
      end
    end else if (k >= KeyDigitOne && k <= KeyDigitZero + cand_cnt) begin
      if (store_cnt < StoreCap) begin
        res.commit_code = cand_buf[k - KeyDigitOne];
        store_cnt++;
        spell_cnt = 0;
        cand_cnt = 0;
        res.action = ActCommit;
      end
    end else if (k == KeyBackspace) begin
      if (spell_cnt > 0) begin
        spell_cnt--;
        lookup_prefix();
        res.action = ActSpellBs;
      end else if (store_cnt > 0) begin
        store_cnt--;
        res.action = ActCommitBs;
      end
    end else if (k == KeyEnter) begin
      if (spell_cnt == 0 && cand_cnt == 0) res.action = ActExit;
      else begin
        spell_cnt = 0;
        cand_cnt = 0;
        res.action = ActClear;
      end
    end
    for (int unsigned i = 0; i < CandCap; i++)
      cands[i] = (i < cand_cnt) ? cand_buf[i] : 16'h0;
    res.spell_len  = 4'(spell_cnt);
    res.cand_cnt   = 3'(cand_cnt);
    res.cand0      = cands[0];
    res.cand1      = cands[1];
    res.cand2      = cands[2];
    res.cand3      = cands[3];
    res.cand4      = cands[4];
    res.commit_len = 6'(store_cnt);
    return res;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_key(logic [7:0] k);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    key_code_i <= k;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(apply_key(k));
    sent_keys++;
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_key(w[i]);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // receiver: random stalls, long hold-off on request, checks every transfer
  always @(posedge clk_i) begin
    key_result_t want;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 16'h0, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (action_taken_o !== want.action)
          report_mismatch("action", 16'(action_taken_o), 16'(want.action));
        if (spelling_length_o !== want.spell_len)
          report_mismatch("spelling length", 16'(spelling_length_o), 16'(want.spell_len));
        if (candidate_count_o !== want.cand_cnt)
          report_mismatch("candidate count", 16'(candidate_count_o), 16'(want.cand_cnt));
        if (candidate_code_0_o !== want.cand0)
          report_mismatch("candidate 0", candidate_code_0_o, want.cand0);
        if (candidate_code_1_o !== want.cand1)
          report_mismatch("candidate 1", candidate_code_1_o, want.cand1);
        if (candidate_code_2_o !== want.cand2)
          report_mismatch("candidate 2", candidate_code_2_o, want.cand2);
        if (candidate_code_3_o !== want.cand3)
          report_mismatch("candidate 3", candidate_code_3_o, want.cand3);
        if (candidate_code_4_o !== want.cand4)
          report_mismatch("candidate 4", candidate_code_4_o, want.cand4);
        if (committed_length_o !== want.commit_len)
          report_mismatch("committed length", 16'(committed_length_o), 16'(want.commit_len));
        if (committed_code_o !== want.commit_code)
          report_mismatch("committed code", committed_code_o, want.commit_code);
      end
    end
  end

  // watchdog: abort after too long without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_edge_keys();
    send_key(KeyEnter);
    send_key(KeyBackspace);
    send_key(KeyDigitOne);
    send_key(KeyDigitZero);
    send_key(8'h00);
    send_key(8'hff);
    send_key(KeyLowA - 8'd1);
    send_key(KeyLowZ + 8'd1);
    send_key(8'h39);
  endtask

  task automatic test_spelling();
    send_word("zhon");
    send_key(8'h67);
    send_key(8'h78);
    send_key(KeyBackspace);
    send_key(KeyBackspace);
    send_key(KeyEnter);
    send_word("m");
    send_key(8'h33);
    send_key(KeyDigitZero);
    send_key(8'h32);
    send_word("abcdefghijk");
    send_key(KeyEnter);
    send_key(KeyEnter);
    send_key(KeyBackspace);
  endtask

  task automatic test_store_full();
    for (int i = 0; i <= StoreCap; i++) begin
      send_key(8'h6e);
      send_key(KeyDigitOne);
    end
    send_key(KeyEnter);
    for (int i = 0; i <= StoreCap; i++) send_key(KeyBackspace);
  endtask

  task automatic test_random(int unsigned quota);
    int unsigned target;
    int unsigned len;
    int unsigned row;
    target = sent_keys + quota;
    while (sent_keys < target) begin
      case ($urandom_range(9, 0))
        0: send_key(8'($urandom_range(255, 0)));
        1: repeat ($urandom_range(4, 1)) send_key(KeyBackspace);
        2: repeat ($urandom_range(12, 1)) send_key(8'($urandom_range(KeyLowZ, KeyLowA)));
        default: begin
          row = $urandom_range(WordCount - 1, 0);
          len = $urandom_range(word_spell[row].len(), 1);
          for (int unsigned p = 0; p < len; p++) send_key(word_spell[row][p]);
          case ($urandom_range(9, 0))
            0: send_key(KeyBackspace);
            1: send_key(KeyEnter);
            2: send_key(KeyDigitOne + 8'($urandom_range(8, 0)));
            default: send_key(KeyDigitOne + 8'($urandom_range(cand_cnt > 0 ? cand_cnt - 1 : 0, 0)));
          endcase
        end
      endcase
    end
  endtask

  // fill the block with the receiver held off, sender still offering keys
  task automatic test_back_pressure();
    hold_off = 300;
    test_random(20);
  endtask

  initial begin
    word_spell = '{"ni", "hao", "ma", "wo", "ta", "men", "ren", "da", "zhong", "guo"};
    word_code  = '{16'hC4E3, 16'hBAC3, 16'hC2F0, 16'hCED2, 16'hCBFB,
                   16'hC3C7, 16'hC8CB, 16'hB4F3, 16'hD6D0, 16'hB9FA};
    spell_cnt = 0;
    cand_cnt = 0;
    store_cnt = 0;
    mismatches = 0;
    sent_keys = 0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    key_code_i = 8'h00;
    out_ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_keys();
    test_spelling();
    test_store_full();
    send_idle_pct = 16;
    recv_idle_pct = 75;
    test_back_pressure();
    test_random(100);
    send_idle_pct = 75;
    recv_idle_pct = 16;
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
